// ----- design/gspe_pkg.sv -----
// Shared constants and control/status types for the shortest-path engine.
// No dependencies; used by every other file of the block except gspe_ram.
package gspe_pkg;

  localparam int unsigned MAX_NODES_DEF  = 16;
  localparam int unsigned COST_BITS_DEF  = 16;

  localparam int unsigned NODE_BITS      = 4;
  localparam int unsigned CNT_BITS       = 5;
  localparam int unsigned FIELD_COST_BITS = 16;
  localparam int unsigned DIST_BITS      = 20;
  localparam int unsigned OUT_BITS       = 21;
  localparam int unsigned IN_TDATA_BITS  = 24;
  localparam int unsigned OUT_TDATA_BITS = 24;

  localparam logic [DIST_BITS-1:0] DIST_SAT       = '1;
  localparam logic [CNT_BITS-1:0]  NODE_COUNT_RST = 5'd16;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic clr_wr;
    logic edge_wr;
    logic capture;
    logic q_init;
    logic scan_rd;
    logic settle;
    logic relax_rd;
    logic next_round;
    logic dst_rd;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic q_bad;
    logic idx_end;
    logic found;
    logic last_round;
    logic out_busy;
  } sts_t;

endpackage

// ----- design/graph_shortest_path_engine_top.sv -----
// Shortest-path engine over a directed weighted graph held as an adjacency matrix.
// Input word (s_axis): tuser = mode, tdata = from_node, to_node, edge_cost.
// An add word (mode 0) stores one edge and gives no output word.
// A query word (mode 1) runs Dijkstra from from_node and returns the distance to
// to_node on m_axis (tdata[20:0], all ones when unreachable).
// A query runs in rounds. Each round is a registered scan of the distance RAM for the
// nearest open node followed by a pass over that node's row of the edge RAM; a round that
// finds no open node ends the search. Out-of-range queries skip the search and return
// all ones. One item is worked on at a time.
// The result sits in an output register; s_axis_tready returns while it waits, and a
// following query stalls at its end until m_axis_tready frees the register.
// After reset the edge RAM is cleared one entry per cycle, all MAX_NODES*MAX_NODES entries
// (256 by default), with s_axis_tready low; node_count writes on the cfg channel are
// taken at any time and reset to 16.
// Depends on gspe_pkg, gspe_ram, gspe_ctrl and gspe_dp.
module graph_shortest_path_engine_top #(
  parameter int unsigned MAX_NODES = gspe_pkg::MAX_NODES_DEF,
  parameter int unsigned COST_BITS = gspe_pkg::COST_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gspe_pkg::CNT_BITS-1:0]       cfg_data_i,       // node_count
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [gspe_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata_i,   // from_node, to_node, edge_cost
  input  logic [0:0]                          s_axis_tuser_i,   // mode
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [gspe_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata_o    // distance, zero pad
);

  gspe_pkg::cmd_t cmd;
  gspe_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  gspe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_mode_i   (s_axis_tuser_i[0]),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gspe_dp #(
    .MAX_NODES (MAX_NODES),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule

// ----- design/gspe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gspe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/gspe_ctrl.sv -----
// Sequencer for the shortest-path engine: clearing pass, edge writes, query rounds.
// Depends on gspe_pkg.
module gspe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic          s_mode_i,
  output logic          s_tready_o,
  input  gspe_pkg::sts_t sts_i,
  output gspe_pkg::cmd_t cmd_o
);

  typedef enum logic [10:0] {
    ST_CLEAR     = 11'b000_0000_0001,
    ST_IDLE      = 11'b000_0000_0010,
    ST_QINIT     = 11'b000_0000_0100,
    ST_SCAN      = 11'b000_0000_1000,
    ST_SCAN_WAIT = 11'b000_0001_0000,
    ST_PICK      = 11'b000_0010_0000,
    ST_RELAX     = 11'b000_0100_0000,
    ST_RLX_WAIT  = 11'b000_1000_0000,
    ST_NEXT_RND  = 11'b001_0000_0000,
    ST_FETCH     = 11'b010_0000_0000,
    ST_RESULT    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i & s_tready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (s_mode_i == gspe_pkg::MODE_QUERY) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_QINIT;
          end else begin
            cmd_o.edge_wr = 1'b1;
          end
        end
      end
      ST_QINIT: begin
        if (sts_i.q_bad) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.q_init = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.idx_end) state_d = ST_SCAN_WAIT;
        else cmd_o.scan_rd = 1'b1;
      end
      ST_SCAN_WAIT: state_d = ST_PICK;
      ST_PICK: begin
        if (sts_i.found) begin
          cmd_o.settle = 1'b1;
          state_d      = ST_RELAX;
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_RELAX: begin
        if (sts_i.idx_end) state_d = ST_RLX_WAIT;
        else cmd_o.relax_rd = 1'b1;
      end
      ST_RLX_WAIT: state_d = ST_NEXT_RND;
      ST_NEXT_RND: begin
        if (sts_i.last_round) begin
          state_d = ST_FETCH;
        end else begin
          cmd_o.next_round = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_FETCH: begin
        cmd_o.dst_rd = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/gspe_dp.sv -----
// Datapath of the shortest-path engine: edge store, distance store, scan and relax logic.
// Depends on gspe_pkg and gspe_ram.
module gspe_dp #(
  parameter int unsigned MAX_NODES = gspe_pkg::MAX_NODES_DEF,
  parameter int unsigned COST_BITS = gspe_pkg::COST_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [gspe_pkg::CNT_BITS-1:0]         cfg_data_i,
  input  logic [gspe_pkg::IN_TDATA_BITS-1:0]    s_tdata_i,
  input  gspe_pkg::cmd_t                        cmd_i,
  output gspe_pkg::sts_t                        sts_o,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  output logic [gspe_pkg::OUT_TDATA_BITS-1:0]   m_tdata_o
);

  localparam int unsigned NW    = $clog2(MAX_NODES);
  localparam int unsigned CW    = $clog2(MAX_NODES + 1);
  localparam int unsigned EDEPTH = MAX_NODES * MAX_NODES;
  localparam int unsigned AW    = $clog2(EDEPTH);
  localparam int unsigned EW    = COST_BITS + 1;
  localparam int unsigned DB    = gspe_pkg::DIST_BITS;
  localparam int unsigned SW    = ((COST_BITS > DB) ? COST_BITS : DB) + 1;
  localparam int unsigned OB    = gspe_pkg::OUT_BITS;

  logic [gspe_pkg::CNT_BITS-1:0]  node_count_q;
  logic [CW-1:0]                  n_act;
  logic [gspe_pkg::NODE_BITS-1:0] in_from, in_to, src_q, dst_q;
  logic [gspe_pkg::FIELD_COST_BITS-1:0] in_cost;
  logic [NW-1:0]                  src_idx, dst_idx, best_q, p_idx_q;
  logic [DB-1:0]                  best_d_q, d_rdata, cand, d_wdata;
  logic [CW-1:0]                  idx_q, round_q;
  logic [AW-1:0]                  clr_q, e_waddr, e_raddr, add_addr;
  logic [EW-1:0]                  e_wdata, e_rdata;
  logic [COST_BITS-1:0]           e_w;
  logic [SW-1:0]                  sum;
  logic [MAX_NODES-1:0]           reached_q, settled_q;
  logic                           found_q, p_scan_q, p_relax_q, m_valid_q;
  logic [OB-1:0]                  m_data_q, res_val;
  logic                           add_ok, e_we, d_we, d_re, scan_hit, relax_upd, q_bad;
  logic [NW-1:0]                  d_waddr, d_raddr;

  assign in_from = s_tdata_i[3:0];
  assign in_to   = s_tdata_i[7:4];
  assign in_cost = s_tdata_i[23:8];
  assign src_idx = NW'(src_q);
  assign dst_idx = NW'(dst_q);

  always_comb begin
    if (node_count_q == '0) begin
      n_act = CW'(1);
    end else if (32'(node_count_q) > MAX_NODES) begin
      n_act = CW'(MAX_NODES);
    end else begin
      n_act = CW'(node_count_q);
    end
  end

  assign q_bad = (32'(src_q) >= 32'(n_act)) || (32'(dst_q) >= 32'(n_act));

  // Edge store: present bit above the cost
  assign add_ok   = (32'(in_from) < MAX_NODES) && (32'(in_to) < MAX_NODES);
  assign add_addr = AW'(in_from) * AW'(MAX_NODES) + AW'(in_to);
  assign e_we     = cmd_i.clr_wr | (cmd_i.edge_wr & add_ok);
  assign e_waddr  = cmd_i.clr_wr ? clr_q : add_addr;
  assign e_wdata  = cmd_i.clr_wr ? '0 : {1'b1, COST_BITS'(in_cost)};
  assign e_raddr  = AW'(best_q) * AW'(MAX_NODES) + AW'(idx_q[NW-1:0]);

  gspe_ram #(
    .WIDTH (EW),
    .DEPTH (EDEPTH)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .re_i    (cmd_i.relax_rd),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  // Relaxation of one out-edge, saturating at the distance ceiling
  assign e_w       = e_rdata[COST_BITS-1:0];
  assign sum       = SW'(best_d_q) + SW'(e_w);
  assign cand      = (sum > SW'(gspe_pkg::DIST_SAT)) ? gspe_pkg::DIST_SAT : sum[DB-1:0];
  assign relax_upd = p_relax_q & e_rdata[COST_BITS] &
                     (!reached_q[p_idx_q] || (cand < d_rdata));
  assign scan_hit  = p_scan_q & reached_q[p_idx_q] & !settled_q[p_idx_q] &
                     (!found_q || (d_rdata < best_d_q));

  assign d_we    = cmd_i.q_init | relax_upd;
  assign d_waddr = cmd_i.q_init ? src_idx : p_idx_q;
  assign d_wdata = cmd_i.q_init ? '0 : cand;
  assign d_re    = cmd_i.scan_rd | cmd_i.relax_rd | cmd_i.dst_rd;
  assign d_raddr = cmd_i.dst_rd ? dst_idx : idx_q[NW-1:0];

  gspe_ram #(
    .WIDTH (DB),
    .DEPTH (MAX_NODES)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  assign res_val = (q_bad || !reached_q[dst_idx]) ? '1 : {1'b0, d_rdata};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= gspe_pkg::NODE_COUNT_RST;
      clr_q        <= '0;
      idx_q        <= '0;
      round_q      <= '0;
      found_q      <= 1'b0;
      p_scan_q     <= 1'b0;
      p_relax_q    <= 1'b0;
      reached_q    <= '0;
      settled_q    <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) node_count_q <= cfg_data_i;
      if (cmd_i.clr_wr) clr_q <= clr_q + AW'(1);
      if (cmd_i.q_init || cmd_i.settle || cmd_i.next_round) begin
        idx_q <= '0;
      end else if (cmd_i.scan_rd || cmd_i.relax_rd) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.q_init) begin
        round_q <= '0;
      end else if (cmd_i.next_round) begin
        round_q <= round_q + CW'(1);
      end
      if (cmd_i.q_init || cmd_i.next_round) begin
        found_q <= 1'b0;
      end else if (scan_hit) begin
        found_q <= 1'b1;
      end
      p_scan_q  <= cmd_i.scan_rd;
      p_relax_q <= cmd_i.relax_rd;
      if (cmd_i.q_init) begin
        reached_q <= {{(MAX_NODES-1){1'b0}}, 1'b1} << src_idx;
        settled_q <= '0;
      end else begin
        if (cmd_i.settle) settled_q[best_q] <= 1'b1;
        if (relax_upd) reached_q[p_idx_q] <= 1'b1;
      end
      if (cmd_i.res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      src_q <= in_from;
      dst_q <= in_to;
    end
    if (cmd_i.scan_rd || cmd_i.relax_rd) p_idx_q <= idx_q[NW-1:0];
    if (scan_hit) begin
      best_q   <= p_idx_q;
      best_d_q <= d_rdata;
    end
    if (cmd_i.res_load) m_data_q <= res_val;
  end

  assign sts_o.clr_done   = (clr_q == AW'(EDEPTH - 1));
  assign sts_o.q_bad      = q_bad;
  assign sts_o.idx_end    = (idx_q == n_act);
  assign sts_o.found      = found_q;
  assign sts_o.last_round = (round_q == (n_act - CW'(1)));
  assign sts_o.out_busy   = m_valid_q & !m_tready_i;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{(gspe_pkg::OUT_TDATA_BITS - OB){1'b0}}, m_data_q};

`ifndef ASSERT_OFF
  a_settle_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.settle |-> found_q)
    else $error("settle without a candidate");
  a_settle_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.settle |=> settled_q[best_q])
    else $error("picked node not marked settled");
  a_relax_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    relax_upd |-> (cand >= best_d_q))
    else $error("relaxed distance below settled distance");
  a_src_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.q_init |=> reached_q[src_idx])
    else $error("source not reached after query start");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> !(m_valid_q && !m_tready_i))
    else $error("result overwrites a stalled word");
`endif

endmodule

// ----- dv/tb_graph_shortest_path_engine_top.sv -----
// Self-checking bench for graph_shortest_path_engine_top: edge writes and
// shortest-path queries on s_axis, distances checked on m_axis against plan
// values or a local Dijkstra predictor. Depends on gspe_pkg and top-level RTL.
module tb_graph_shortest_path_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gspe_pkg::*;

  localparam logic [OUT_BITS-1:0] NO_PATH = '1;
  localparam int ADD_SETTLE = 16;
  localparam int END_SETTLE = 700;
  localparam int PHASE_WORDS = 325;
  localparam int PLAN_LEN = 28;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic                       mode;
    logic [NODE_BITS-1:0]       src;
    logic [NODE_BITS-1:0]       dst;
    logic [FIELD_COST_BITS-1:0] cost;
    logic [CNT_BITS-1:0]        count;
    logic                       typed;
    logic [OUT_BITS-1:0]        want;
  } plan_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CNT_BITS-1:0]       cfg_data_i = '0;
  logic                      s_axis_tvalid_i = 1'b0;
  logic                      s_axis_tready_o;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i = '0;
  logic [0:0]                s_axis_tuser_i = '0;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o;

  bit                         graph_link [16][16];
  logic [FIELD_COST_BITS-1:0] graph_cost [16][16];
  logic [CNT_BITS-1:0]        nodes_cfg = NODE_COUNT_RST;
  logic [OUT_BITS-1:0]        pending_distance [$];

  int err_count = 0;
  int words_pushed = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit calm = 1'b0;

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_WORD, MODE_QUERY, 4'd0,  4'd5,  16'd0,      5'd0,  1'b1, NO_PATH},
    '{ROW_WORD, MODE_QUERY, 4'd3,  4'd3,  16'd0,      5'd0,  1'b1, 21'd0},
    '{ROW_WORD, MODE_ADD,   4'd0,  4'd1,  16'd0,      5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_ADD,   4'd1,  4'd2,  16'hFFFF,   5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd0,  4'd2,  16'd0,      5'd0,  1'b1, 21'd65535},
    '{ROW_WORD, MODE_ADD,   4'd0,  4'd2,  16'd100,    5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd0,  4'd2,  16'd0,      5'd0,  1'b1, 21'd100},
    '{ROW_WORD, MODE_ADD,   4'd0,  4'd2,  16'd200,    5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd0,  4'd2,  16'd0,      5'd0,  1'b1, 21'd200},
    '{ROW_WORD, MODE_ADD,   4'd15, 4'd14, 16'hAAAA,   5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_ADD,   4'd14, 4'd15, 16'h5555,   5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd15, 4'd14, 16'd0,      5'd0,  1'b1, 21'h00AAAA},
    '{ROW_WORD, MODE_QUERY, 4'd2,  4'd0,  16'd0,      5'd0,  1'b1, NO_PATH},
    '{ROW_CFG,  MODE_ADD,   4'd0,  4'd0,  16'd0,      5'd2,  1'b0, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd0,  4'd2,  16'd0,      5'd0,  1'b1, NO_PATH},
    '{ROW_WORD, MODE_QUERY, 4'd0,  4'd1,  16'd0,      5'd0,  1'b1, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd15, 4'd14, 16'd0,      5'd0,  1'b1, NO_PATH},
    '{ROW_CFG,  MODE_ADD,   4'd0,  4'd0,  16'd0,      5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd0,  4'd0,  16'd0,      5'd0,  1'b1, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd0,  4'd1,  16'd0,      5'd0,  1'b1, NO_PATH},
    '{ROW_CFG,  MODE_ADD,   4'd0,  4'd0,  16'd0,      5'd31, 1'b0, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd15, 4'd14, 16'd0,      5'd0,  1'b1, 21'h00AAAA},
    '{ROW_WORD, MODE_ADD,   4'd2,  4'd3,  16'd1,      5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_ADD,   4'd3,  4'd15, 16'd1,      5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd0,  4'd15, 16'd0,      5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_ADD,   4'd1,  4'd3,  16'd7,      5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd0,  4'd15, 16'd0,      5'd0,  1'b0, 21'd0},
    '{ROW_WORD, MODE_QUERY, 4'd2,  4'd14, 16'd0,      5'd0,  1'b0, 21'd0}
  };

  graph_shortest_path_engine_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [OUT_BITS-1:0] shortest_distance(input logic [NODE_BITS-1:0] src,
                                                            input logic [NODE_BITS-1:0] dst);
    int n;
    int best;
    logic [DIST_BITS-1:0] node_dist [16];
    bit settled [16];
    bit reached [16];
    logic [DIST_BITS:0] cand;
    n = (nodes_cfg == 0) ? 1 : ((nodes_cfg > 16) ? 16 : int'(nodes_cfg));
    if (src >= n || dst >= n) return NO_PATH;
    for (int i = 0; i < 16; i++) begin
      node_dist[i] = '0;
      settled[i] = 1'b0;
      reached[i] = 1'b0;
    end
    reached[src] = 1'b1;
    for (int r = 0; r < n; r++) begin
      best = n;
      for (int i = 0; i < n; i++) begin
        if (reached[i] && !settled[i] && (best == n || node_dist[i] < node_dist[best]))
          best = i;
      end
      if (best == n) break;
      settled[best] = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (graph_link[best][i]) begin
          cand = {1'b0, node_dist[best]} + {5'b0, graph_cost[best][i]};
          if (cand > {1'b0, DIST_SAT}) cand = {1'b0, DIST_SAT};
          if (!reached[i] || cand[DIST_BITS-1:0] < node_dist[i]) begin
            node_dist[i] = cand[DIST_BITS-1:0];
            reached[i] = 1'b1;
          end
        end
      end
    end
    return reached[dst] ? {1'b0, node_dist[dst]} : NO_PATH;
  endfunction

  function automatic logic [FIELD_COST_BITS-1:0] pick_cost();
    case ($urandom_range(3))
      0: return 16'hFFFF;
      1: return 16'($urandom_range(16'hFFFF, 16'hF000));
      2: return 16'($urandom_range(15));
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [CNT_BITS-1:0] pick_count();
    case ($urandom_range(5))
      0: return 5'd16;
      1: return 5'($urandom_range(31, 17));
      2: return 5'($urandom_range(1));
      default: return 5'($urandom_range(16, 2));
    endcase
  endfunction

  task automatic note_fail(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Entered and left just after a falling edge.
  task automatic push_word(input logic mode, input logic [NODE_BITS-1:0] src,
                           input logic [NODE_BITS-1:0] dst,
                           input logic [FIELD_COST_BITS-1:0] cost,
                           input logic typed, input logic [OUT_BITS-1:0] want);
    if (!calm) begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i = mode;
    s_axis_tdata_i = {cost, dst, src};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (mode == MODE_ADD) begin
      graph_link[src][dst] = 1'b1;
      graph_cost[src][dst] = cost;
    end else begin
      pending_distance.push_back(typed ? want : shortest_distance(src, dst));
    end
    words_pushed++;
    @(negedge clk_i);
  endtask

  task automatic write_node_count(input logic [CNT_BITS-1:0] value);
    s_axis_tvalid_i = 1'b0;
    while (pending_distance.size() != 0) @(posedge clk_i);
    repeat (ADD_SETTLE) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    nodes_cfg = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_traffic(input int quota);
    int start;
    int cfg_mark;
    int k;
    int r;
    int j;
    logic [NODE_BITS-1:0] order [16];
    logic [NODE_BITS-1:0] tmp;
    start = words_pushed;
    cfg_mark = words_pushed;
    while (words_pushed - start < quota) begin
      if (words_pushed - cfg_mark >= 110) begin
        write_node_count(pick_count());
        cfg_mark = words_pushed;
      end
      calm = ($urandom_range(4) == 0);
      r = $urandom_range(99);
      if (r < 55) begin
        for (int i = 0; i < 16; i++) order[i] = 4'(i);
        for (int i = 15; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        k = ($urandom_range(7) == 0) ? 16 : $urandom_range(7, 2);
        for (int i = 0; i < k - 1; i++) begin
          push_word(MODE_ADD, order[i], order[i+1], pick_cost(), 1'b0, '0);
        end
        push_word(MODE_QUERY, order[0], order[k-1], 16'($urandom_range(16'hFFFF)), 1'b0, '0);
        push_word(MODE_QUERY, order[$urandom_range(k-1)], order[$urandom_range(k-1)],
                  16'($urandom_range(16'hFFFF)), 1'b0, '0);
      end else if (r < 75) begin
        push_word(MODE_ADD, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  16'($urandom_range(16'hFFFF)), 1'b0, '0);
      end else begin
        push_word(MODE_QUERY, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  16'($urandom_range(16'hFFFF)), 1'b0, '0);
      end
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_distance.size() == 0) begin
        note_fail($sformatf("unexpected distance word %h", m_axis_tdata_o));
      end else if (m_axis_tdata_o[OUT_BITS-1:0] !== pending_distance[0]) begin
        note_fail($sformatf("distance mismatch: expected %h, got %h",
                            pending_distance[0], m_axis_tdata_o[OUT_BITS-1:0]));
        void'(pending_distance.pop_front());
      end else begin
        void'(pending_distance.pop_front());
      end
    end
  end

  initial begin
    for (int a = 0; a < 16; a++) begin
      for (int b = 0; b < 16; b++) begin
        graph_link[a][b] = 1'b0;
        graph_cost[a][b] = '0;
      end
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        write_node_count(plan[i].count);
      end else begin
        push_word(plan[i].mode, plan[i].src, plan[i].dst, plan[i].cost,
                  plan[i].typed, plan[i].want);
      end
    end
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      write_node_count((p == 0) ? 5'd16 : pick_count());
      run_traffic(PHASE_WORDS);
    end
    s_axis_tvalid_i = 1'b0;
    while (pending_distance.size() != 0) @(posedge clk_i);
    repeat (END_SETTLE) @(posedge clk_i);
    if (err_count == 0 && pending_distance.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
